// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the hash table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the given reset is asserted.
`define MHT_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error(msg);

// Same, on the checker's own clk and arst_n.
`define MHT_ASSERT(lbl, prop, msg) `MHT_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== src/mht_pkg.sv =====
// ---------------------------------------------------------------------------
// MAC hash table package
// Field widths, operation codes and status codes of the hash table.
// ---------------------------------------------------------------------------
package mht_pkg;

	localparam int MAC_W    = 48;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 11;
	// Sum of four key bytes fits in ten bits.
	localparam int SUM_W    = 10;

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [MAC_W-1:0]    mac_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CNT_W-1:0]    count_t;

	// Outcome of one bucket update.
	typedef struct packed {
		logic    wr;
		logic    inc;
		logic    dec;
		status_t status;
	} upd_t;

endpackage

// ===== src/mht_channels.sv =====
// ---------------------------------------------------------------------------
// MAC hash table channels
// Valid/ready interfaces for the request and response beats.
// ---------------------------------------------------------------------------
interface mht_req_if;
	logic           valid;
	logic           ready;
	mht_pkg::func_t func;
	mht_pkg::mac_t  mac;

	modport source(output valid, output func, output mac, input ready);
	modport sink(input valid, input func, input mac, output ready);
endinterface

interface mht_rsp_if;
	logic             valid;
	logic             ready;
	mht_pkg::status_t status;
	mht_pkg::count_t  entry_count;

	modport source(output valid, output status, output entry_count, input ready);
	modport sink(input valid, input status, input entry_count, output ready);
endinterface

// ===== src/mht_update.sv =====
// ---------------------------------------------------------------------------
// MAC hash table bucket update
// Applies insert, delete or search to one bucket row read from memory.
// ---------------------------------------------------------------------------
module mht_update #(
	parameter int WAYS = 4
) (
	input  mht_pkg::func_t              func,
	input  mht_pkg::mac_t               mac,
	input  logic [WAYS-1:0]             row_valid,
	input  logic [WAYS*mht_pkg::MAC_W-1:0] row_keys,
	output logic [WAYS-1:0]             new_valid,
	output logic [WAYS*mht_pkg::MAC_W-1:0] new_keys,
	output mht_pkg::upd_t               upd
);

	logic [WAYS-1:0] free;
	logic [WAYS-1:0] free_1h;
	logic [WAYS-1:0] match;
	logic [WAYS-1:0] match_1h;

	// Lowest free slot and lowest matching slot, as one-hot vectors.
	always_comb begin
		free = ~row_valid;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = row_valid[w] && (row_keys[w*mht_pkg::MAC_W +: mht_pkg::MAC_W] == mac);
		end
		free_1h  = free & (~free + WAYS'(1));
		match_1h = match & (~match + WAYS'(1));
	end

	always_comb begin
		new_valid  = row_valid;
		new_keys   = row_keys;
		upd.wr     = 1'b0;
		upd.inc    = 1'b0;
		upd.dec    = 1'b0;
		upd.status = mht_pkg::ST_MISS;
		case (func)
			mht_pkg::OP_INSERT: begin
				if (|free) begin
					new_valid = row_valid | free_1h;
					for (int w = 0; w < WAYS; w++) begin
						if (free_1h[w]) begin
							new_keys[w*mht_pkg::MAC_W +: mht_pkg::MAC_W] = mac;
						end
					end
					upd.wr     = 1'b1;
					upd.inc    = 1'b1;
					upd.status = mht_pkg::ST_DONE;
				end else begin
					upd.status = mht_pkg::ST_FULL;
				end
			end
			mht_pkg::OP_DELETE: begin
				if (|match) begin
					new_valid  = row_valid & ~match_1h;
					upd.wr     = 1'b1;
					upd.dec    = 1'b1;
					upd.status = mht_pkg::ST_DONE;
				end
			end
			mht_pkg::OP_SEARCH: begin
				if (|match) begin
					upd.status = mht_pkg::ST_DONE;
				end
			end
			default: begin
				upd.status = mht_pkg::ST_MISS;
			end
		endcase
	end

endmodule

// ===== src/mac_address_hash_table_core.sv =====
// ---------------------------------------------------------------------------
// MAC address hash table core
// Insert, delete and search of 48-bit MAC keys in a bucketed table.
// ---------------------------------------------------------------------------
// Usage: each request beat on req carries an operation (func) and a key
// (mac). Every request yields exactly one response beat on rsp with a status
// and the number of live entries after the operation.
// Sequencing: the response is registered and becomes valid once the request
// has passed through the HASH and EXEC states. The sequencer runs one request
// at a time through three steps: accept and start the hash, finish the bucket
// index and read the bucket row, then compare, write the row back and load
// the response register. No new request is taken until the last one has
// left EXEC, and EXEC holds while an earlier response still waits on rsp.
// Reset: arst_n clears the control state, then a sweep writes every bucket
// row empty; req.ready stays low during the sweep.
// Stalls: the next request may be accepted while a response still waits on
// rsp. That request then holds in its execute step until the waiting
// response beat is taken, so no result is lost or reordered.
// ---------------------------------------------------------------------------
module mac_address_hash_table_core #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4
) (
	input logic        clk,
	input logic        arst_n,
	mht_req_if.sink    req,
	mht_rsp_if.source  rsp
);

	localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int KEYS_W   = WAYS * mht_pkg::MAC_W;
	localparam int ROW_W    = KEYS_W + WAYS;
	// Bucket index is sum mod BUCKETS, done as a multiply by a scaled
	// reciprocal. With sums below 1024 and a shift of 20 the quotient is exact.
	localparam int RECIP_SH = 20;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int RECIP    = ((1 << RECIP_SH) + BUCKETS - 1) / BUCKETS;
	localparam int PROD_W   = mht_pkg::SUM_W + RECIP_W;
	localparam int QB_W     = mht_pkg::SUM_W + BKT_W + 1;

	// Sequencer states.
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HASH  = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0]                    state_q;
	logic [BKT_W-1:0]              clr_q;
	mht_pkg::count_t               count_q;
	logic                          rsp_valid_q;

	mht_pkg::func_t                func_q;
	mht_pkg::mac_t                 mac_q;
	logic [mht_pkg::SUM_W-1:0]     sum_s1;
	logic [mht_pkg::SUM_W-1:0]     quo_s1;
	logic [BKT_W-1:0]              bkt_q;
	mht_pkg::status_t              rsp_status_q;
	mht_pkg::count_t               rsp_count_q;

	logic [ROW_W-1:0]              slot_mem_q [BUCKETS];
	logic [ROW_W-1:0]              rd_row_q;

	logic [mht_pkg::SUM_W-1:0]     sum_d;
	logic [PROD_W-1:0]             prod_d;
	logic [QB_W-1:0]               qb_d;
	logic [mht_pkg::SUM_W-1:0]     rem_d;
	logic [BKT_W-1:0]              bkt_d;

	logic                          accept;
	logic                          exec_go;
	logic                          mem_we;
	logic [BKT_W-1:0]              mem_waddr;
	logic [ROW_W-1:0]              mem_wdata;

	logic [WAYS-1:0]               new_valid;
	logic [KEYS_W-1:0]             new_keys;
	mht_pkg::upd_t                 upd;

	assign req.ready       = (state_q == S_IDLE);
	assign accept          = req.valid && req.ready;
	assign exec_go         = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	// Byte sum of the low four key bytes (bytes 2 to 5 in wire order), then
	// the reciprocal multiply; the quotient is registered before use.
	always_comb begin
		sum_d = mht_pkg::SUM_W'(req.mac[7:0]) + mht_pkg::SUM_W'(req.mac[15:8])
			+ mht_pkg::SUM_W'(req.mac[23:16]) + mht_pkg::SUM_W'(req.mac[31:24]);
		prod_d = PROD_W'(sum_d) * PROD_W'(RECIP);
	end

	// Remainder from the registered quotient gives the bucket row.
	always_comb begin
		qb_d  = QB_W'(quo_s1) * QB_W'(BUCKETS);
		rem_d = sum_s1 - qb_d[mht_pkg::SUM_W-1:0];
		bkt_d = rem_d[BKT_W-1:0];
	end

	mht_update #(
		.WAYS(WAYS)
	) u_update (
		.func     (func_q),
		.mac      (mac_q),
		.row_valid(rd_row_q[ROW_W-1 -: WAYS]),
		.row_keys (rd_row_q[KEYS_W-1:0]),
		.new_valid(new_valid),
		.new_keys (new_keys),
		.upd      (upd)
	);

	// The clearing sweep and the write-back share the one write port.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = bkt_q;
		mem_wdata = {new_valid, new_keys};
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (exec_go && upd.wr) begin
			mem_we = 1'b1;
		end
	end

	// Bucket memory: one row per bucket, valid bits on top of the keys.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_HASH) begin
			rd_row_q <= slot_mem_q[bkt_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// The count wraps with the 11-bit field; a delete only happens
			// on a hit, so it never underflows the true count.
			if (exec_go) begin
				count_q <= count_q + mht_pkg::CNT_W'(upd.inc) - mht_pkg::CNT_W'(upd.dec);
			end

			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			mac_q  <= req.mac;
			sum_s1 <= sum_d;
			quo_s1 <= prod_d[RECIP_SH +: mht_pkg::SUM_W];
		end
		if (state_q == S_HASH) begin
			bkt_q <= bkt_d;
		end
		if (exec_go) begin
			rsp_status_q <= upd.status;
			rsp_count_q  <= count_q + mht_pkg::CNT_W'(upd.inc) - mht_pkg::CNT_W'(upd.dec);
		end
	end

endmodule

// ===== src/mht_checker.sv =====
// ---------------------------------------------------------------------------
// MAC hash table port checker
// Watches the request and response ports of the core over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mht_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input mht_pkg::status_t  rsp_status,
	input mht_pkg::count_t   rsp_entry_count
);

	// The core works on one request at a time.
	`MHT_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

	// No response can be produced in the cycle right after a request beat.
	`MHT_ASSERT(a_no_early_rsp, (req_valid && req_ready) |=> (!rsp_valid || $past(rsp_valid && !rsp_ready)), "response too early")

	// A stalled response beat stays valid.
	`MHT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped while stalled")

	// A stalled response beat keeps its payload.
	`MHT_ASSERT(a_rsp_stable, (rsp_valid && !rsp_ready) |=> ($stable(rsp_status) && $stable(rsp_entry_count)), "response payload changed while stalled")

endmodule

bind mac_address_hash_table_core mht_checker u_mht_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_entry_count(rsp.entry_count)
);

// ===== tb/sv/mac_address_hash_table_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MAC address hash table core testbench
// Sends insert, delete, search and unused-code request beats with random
// gaps, takes response beats with random stalls, and checks each response
// against a scoreboard fed by a behavioral model of the bucketed table.
// ---------------------------------------------------------------------------
module mac_address_hash_table_core_test;

	localparam int BUCKETS = 256;
	localparam int WAYS    = 4;
	localparam int SLOTS   = BUCKETS * WAYS;

	// The two-bit operation field has one code that the table does not use.
	localparam mht_pkg::func_t OP_UNUSED = 2'd3;

	// Cycles with no beat on either channel before the run is declared hung.
	// The longest legal quiet stretch is the long receiver hold below plus a
	// sender gap, and the reset sweep at the start.
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 500;
	localparam int HOLD_TRIGGER = 150;
	localparam int TAIL_CYCLES  = 20;

	localparam mht_pkg::mac_t KEY_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam mht_pkg::mac_t KEY_ZERO = 48'h0000_0000_0000;

	typedef struct packed {
		mht_pkg::status_t status;
		mht_pkg::count_t  entry_count;
	} outcome_t;

	// One row of the directed table. Where known is set, the typed outcome
	// is the expectation; otherwise the model supplies it.
	typedef struct packed {
		mht_pkg::func_t   op;
		mht_pkg::mac_t    key;
		logic             known;
		mht_pkg::status_t status;
		mht_pkg::count_t  entry_count;
	} dir_row_t;

	localparam int DIR_N = 22;

	// Keys 48'h..._0000_0000, 48'h0000_0000_FF01 all land in bucket 0, the
	// all-ones key in bucket 252. Byte0 and byte1 never enter the hash.
	dir_row_t dir_rows [DIR_N] = '{
		// Empty table after reset: search and delete both miss.
		'{mht_pkg::OP_SEARCH, KEY_ZERO, 1'b1, mht_pkg::ST_MISS, 11'd0},
		'{mht_pkg::OP_DELETE, KEY_ZERO, 1'b1, mht_pkg::ST_MISS, 11'd0},
		// The all-ones key twice: duplicates take a slot each.
		'{mht_pkg::OP_INSERT, KEY_MAX,  1'b1, mht_pkg::ST_DONE, 11'd1},
		'{mht_pkg::OP_INSERT, KEY_MAX,  1'b1, mht_pkg::ST_DONE, 11'd2},
		'{mht_pkg::OP_SEARCH, KEY_MAX,  1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_DELETE, KEY_MAX,  1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_SEARCH, KEY_MAX,  1'b0, mht_pkg::ST_DONE, 11'd0},
		// The unused code leaves the table alone and reports a miss.
		'{OP_UNUSED,          KEY_MAX,  1'b1, mht_pkg::ST_MISS, 11'd1},
		// Fill bucket 0, then overflow it.
		'{mht_pkg::OP_INSERT, KEY_ZERO,           1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_INSERT, 48'hFFFF_0000_0000, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_INSERT, 48'h0000_0000_FF01, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_INSERT, 48'h1234_0000_0000, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_INSERT, 48'hAAAA_0000_0000, 1'b1, mht_pkg::ST_FULL, 11'd5},
		'{mht_pkg::OP_SEARCH, 48'hAAAA_0000_0000, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_SEARCH, 48'h0000_0000_FF01, 1'b0, mht_pkg::ST_DONE, 11'd0},
		// Free a middle slot and refill it.
		'{mht_pkg::OP_DELETE, 48'hFFFF_0000_0000, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_INSERT, 48'hAAAA_0000_0000, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_DELETE, KEY_ZERO,           1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_SEARCH, 48'h5555_5555_5555, 1'b0, mht_pkg::ST_DONE, 11'd0},
		'{OP_UNUSED,          KEY_ZERO,           1'b0, mht_pkg::ST_DONE, 11'd0},
		// Last copy of the duplicate goes, then a delete of a key now absent.
		'{mht_pkg::OP_DELETE, KEY_MAX,  1'b0, mht_pkg::ST_DONE, 11'd0},
		'{mht_pkg::OP_DELETE, KEY_MAX,  1'b1, mht_pkg::ST_MISS, 11'd3}
	};

	logic clk;
	logic arst_n;

	mht_req_if req_ch();
	mht_rsp_if rsp_ch();

	mac_address_hash_table_core #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Model state: keys, valid bits and the live count of the table.
	mht_pkg::mac_t table_keys [SLOTS];
	logic          table_live [SLOTS];
	int unsigned   table_count;

	outcome_t pending_outcomes [$];

	int fail_count;
	int beats_sent;
	int beats_seen;
	int full_seen;
	int miss_seen;
	int peak_count;
	int cycle_no;
	int idle_cycles;
	int hot_buckets [8];

	// -----------------------------------------------------------------------
	// Clock.
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Behavioral model of the table.
	// -----------------------------------------------------------------------

	// Bucket index: sum of the four low bytes of the key, modulo BUCKETS.
	function automatic int bucket_of(mht_pkg::mac_t key);
		int sum;
		sum = int'(key[7:0]) + int'(key[15:8]) + int'(key[23:16]) + int'(key[31:24]);
		return sum % BUCKETS;
	endfunction

	// Applies one operation to the model and returns the response it yields.
	// Delete and search look only at valid slots and stop at the lowest
	// matching one; insert takes the lowest free slot or reports full.
	function automatic outcome_t apply_operation(mht_pkg::func_t op, mht_pkg::mac_t key);
		outcome_t res;
		int       base;
		int       hit;
		logic     placed;
		base       = bucket_of(key) * WAYS;
		hit        = -1;
		placed     = 1'b0;
		res.status = mht_pkg::ST_MISS;
		case (op)
			mht_pkg::OP_INSERT: begin
				res.status = mht_pkg::ST_FULL;
				for (int w = 0; w < WAYS; w++) begin
					if (!placed && !table_live[base + w]) begin
						table_live[base + w] = 1'b1;
						table_keys[base + w] = key;
						table_count++;
						placed     = 1'b1;
						res.status = mht_pkg::ST_DONE;
					end
				end
			end
			mht_pkg::OP_DELETE, mht_pkg::OP_SEARCH: begin
				for (int w = 0; w < WAYS; w++) begin
					if (hit < 0 && table_live[base + w] && table_keys[base + w] == key)
						hit = base + w;
				end
				if (hit >= 0) begin
					res.status = mht_pkg::ST_DONE;
					if (op == mht_pkg::OP_DELETE) begin
						table_live[hit] = 1'b0;
						if (table_count > 0)
							table_count--;
					end
				end
			end
			default: begin
			end
		endcase
		res.entry_count = mht_pkg::count_t'(table_count % 2048);
		return res;
	endfunction

	// Number of valid slots in a bucket, used to steer the fill phase.
	function automatic int bucket_fill(int b);
		int n;
		n = 0;
		for (int w = 0; w < WAYS; w++)
			if (table_live[b * WAYS + w])
				n++;
		return n;
	endfunction

	// A random key whose four low bytes sum to b modulo 256. With BUCKETS a
	// divisor of 256 that places the key in bucket b.
	function automatic mht_pkg::mac_t key_for_bucket(int b);
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
		logic [7:0] b5;
		b2 = 8'($urandom);
		b3 = 8'($urandom);
		b4 = 8'($urandom);
		b5 = 8'(b - int'(b2) - int'(b3) - int'(b4));
		return {16'($urandom), b2, b3, b4, b5};
	endfunction

	// A key that is in the table when the chosen slot is live, otherwise a
	// fresh key for that slot's bucket. Only live slots are ever read.
	function automatic mht_pkg::mac_t key_from_slot(int s);
		if (table_live[s])
			return table_keys[s];
		return key_for_bucket(s / WAYS);
	endfunction

	// -----------------------------------------------------------------------
	// Request side.
	// -----------------------------------------------------------------------

	// Gap after a request beat. Every fourth stretch of 150 beats runs back
	// to back; otherwise most gaps are short and a few are long.
	function automatic int sender_gap();
		int r;
		if ((beats_sent / 150) % 4 == 3)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// Offers one request beat, waits until it is taken, then records the
	// expected response. Valid stays high into the next beat unless a gap
	// follows, so it is never lowered and raised in the same step.
	task automatic send_request(mht_pkg::func_t op, mht_pkg::mac_t key, logic known,
		mht_pkg::status_t st, mht_pkg::count_t cnt);
		outcome_t res;
		int       gap;
		req_ch.valid <= 1'b1;
		req_ch.func  <= op;
		req_ch.mac   <= key;
		do
			@(posedge clk);
		while (!req_ch.ready);
		res = apply_operation(op, key);
		if (known) begin
			res.status      = st;
			res.entry_count = cnt;
		end
		pending_outcomes.push_back(res);
		beats_sent++;
		gap = sender_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected response has arrived.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Mixed random traffic. Most keys come from a few hot buckets so that
	// buckets fill, overflow and have live keys to delete or find; the rest
	// hit anywhere. ins_pct sets the share of inserts.
	task automatic random_traffic(int n, int ins_pct);
		mht_pkg::func_t op;
		mht_pkg::mac_t  key;
		int             r;
		int             k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = mht_pkg::OP_INSERT;
			else if (r < ins_pct + (96 - ins_pct) / 2)
				op = mht_pkg::OP_DELETE;
			else if (r < 96)
				op = mht_pkg::OP_SEARCH;
			else
				op = OP_UNUSED;
			k = $urandom_range(0, 9);
			if (k < 5)
				key = key_from_slot(hot_buckets[$urandom_range(0, 7)] * WAYS
					+ $urandom_range(0, WAYS - 1));
			else if (k == 5)
				key = key_from_slot($urandom_range(0, SLOTS - 1));
			else if (k < 8)
				key = key_for_bucket(hot_buckets[$urandom_range(0, 7)]);
			else
				key = {16'($urandom), $urandom};
			send_request(op, key, 1'b0, mht_pkg::ST_DONE, '0);
		end
	endtask

	// Top up every bucket to full so the live count reaches the table size;
	// every sixteenth bucket also gets one insert too many.
	task automatic fill_table();
		int need;
		for (int b = 0; b < BUCKETS; b++) begin
			need = WAYS - bucket_fill(b);
			if (b % 16 == 0)
				need++;
			repeat (need) send_request(mht_pkg::OP_INSERT, key_for_bucket(b), 1'b0,
				mht_pkg::ST_DONE, '0);
		end
		// A few searches against the full table, present and absent keys.
		repeat (16) send_request(mht_pkg::OP_SEARCH,
			key_from_slot($urandom_range(0, SLOTS - 1)), 1'b0, mht_pkg::ST_DONE, '0);
		repeat (8) send_request(mht_pkg::OP_SEARCH, {16'($urandom), $urandom}, 1'b0,
			mht_pkg::ST_DONE, '0);
	endtask

	// -----------------------------------------------------------------------
	// Main sequence: reset, directed table, random mix, full table, a
	// delete-heavy mix, then the tail and the verdict. The sender pauses
	// until the scoreboard is empty between phases.
	// -----------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func  = mht_pkg::OP_SEARCH;
		req_ch.mac   = '0;
		table_count  = 0;
		fail_count   = 0;
		beats_sent   = 0;
		for (int s = 0; s < SLOTS; s++) begin
			table_live[s] = 1'b0;
			table_keys[s] = '0;
		end
		for (int h = 0; h < 8; h++)
			hot_buckets[h] = $urandom_range(0, BUCKETS - 1);
		// Keep the two extreme buckets among the hot ones.
		hot_buckets[0] = 0;
		hot_buckets[1] = BUCKETS - 1;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].known,
				dir_rows[i].status, dir_rows[i].entry_count);
		drain_responses();

		random_traffic(400, 45);
		drain_responses();

		fill_table();
		drain_responses();

		random_traffic(300, 15);
		drain_responses();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d request beats and %0d responses: %0d bucket-full, %0d misses.",
			beats_sent, beats_seen, full_seen, miss_seen);
		$display("Live entry count peaked at %0d of %0d slots.", peak_count, SLOTS);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Response side. Ready drops for short stalls most of the time and for a
	// longer one now and then, every third stretch of the run has no
	// stalls, and once the receiver holds off for HOLD_CYCLES while requests
	// keep coming, so the core backs up and stalls its input.
	// -----------------------------------------------------------------------
	initial begin
		int   stall_left;
		int   r;
		logic long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		rsp_ch.ready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_hold_done && beats_seen >= HOLD_TRIGGER) begin
				long_hold_done = 1'b1;
				stall_left     = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if ((cycle_no / 400) % 3 == 2) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					stall_left   = $urandom_range(0, 2);
					rsp_ch.ready <= 1'b0;
				end else if (r < 12) begin
					stall_left   = $urandom_range(15, 60);
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Scoreboard: every response beat is matched in order against the oldest
	// expected outcome, field by field.
	// -----------------------------------------------------------------------
	initial begin
		beats_seen = 0;
		full_seen  = 0;
		miss_seen  = 0;
		peak_count = 0;
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			beats_seen++;
			if (rsp_ch.status == mht_pkg::ST_FULL)
				full_seen++;
			if (rsp_ch.status == mht_pkg::ST_MISS)
				miss_seen++;
			if (int'(rsp_ch.entry_count) > peak_count)
				peak_count = int'(rsp_ch.entry_count);
			if (pending_outcomes.size() == 0) begin
				$error("response beat with nothing expected: status %0d entry_count %0d",
					rsp_ch.status, rsp_ch.entry_count);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d",
						want.entry_count, rsp_ch.entry_count);
					fail_count++;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Watchdog: counts the stretch in which no beat moves on either channel
	// and ends the run when that count reaches IDLE_LIMIT.
	// -----------------------------------------------------------------------
	initial begin
		cycle_no    = 0;
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		cycle_no++;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles, %0d responses still expected.",
				IDLE_LIMIT, pending_outcomes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
